// ----- hw/rtl/hrhp_pkg.sv -----
// Shared types, codes and character-class functions for the HTTP request header parser.
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

  // Parse phases; codes 20..31 are never entered and reject every byte
  typedef enum logic [4:0] {
    PH_METHOD_START = 5'd0,
    PH_METHOD       = 5'd1,
    PH_URI          = 5'd2,
    PH_V_H          = 5'd3,
    PH_V_T1         = 5'd4,
    PH_V_T2         = 5'd5,
    PH_V_P          = 5'd6,
    PH_V_SLASH      = 5'd7,
    PH_MAJ_START    = 5'd8,
    PH_MAJ          = 5'd9,
    PH_MIN_START    = 5'd10,
    PH_MIN          = 5'd11,
    PH_NL1          = 5'd12,
    PH_LINE_START   = 5'd13,
    PH_LWS          = 5'd14,
    PH_NAME         = 5'd15,
    PH_SP_VALUE     = 5'd16,
    PH_VALUE        = 5'd17,
    PH_NL2          = 5'd18,
    PH_NL3          = 5'd19
  } phase_t;

  // Status codes
  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_GOOD = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Byte role codes
  localparam logic [2:0] RL_NONE     = 3'd0;
  localparam logic [2:0] RL_METHOD   = 3'd1;
  localparam logic [2:0] RL_URI      = 3'd2;
  localparam logic [2:0] RL_NEW_NAME = 3'd3;
  localparam logic [2:0] RL_NAME     = 3'd4;
  localparam logic [2:0] RL_VALUE    = 3'd5;

  // Characters of the grammar
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_US    = 8'h1F;

  localparam logic [15:0] VER_MAX = 16'hFFFF;

  // Control character: 0..31 or DEL; high bytes are not controls
  function automatic logic ctl_byte(input logic [7:0] b);
    ctl_byte = (b <= CH_US) || (b == CH_DEL);
  endfunction

  // Separator set of the token grammar
  function automatic logic sep_byte(input logic [7:0] b);
    logic r;
    r = 1'b0;
    unique case (b)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    sep_byte = r;
  endfunction

  // Legal token character: 7-bit, not control, not separator
  function automatic logic token_byte(input logic [7:0] b);
    token_byte = !b[7] && !ctl_byte(b) && !sep_byte(b);
  endfunction

  function automatic logic digit_byte(input logic [7:0] b);
    digit_byte = (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // acc*10 + digit, saturating at 65535
  function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [7:0] b);
    logic [19:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, b[3:0]};
    acc_digit = (v > {4'd0, VER_MAX}) ? VER_MAX : v[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/http_request_header_parser_top.sv -----
// HTTP request header parser: byte-wide parse state machine with a registered result word.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_byte[7:0]
//   out_    | output    | out_valid/out_stall | out_status, out_byte_role, out_byte_out,
//           |           |                     | out_ver_major, out_ver_minor
//
// One word per cycle unless stalled; a result shows the cycle after its byte is taken.
// The parse phase, header flag and version accumulators update at the accept edge,
// so the next byte can follow immediately.
// in_stall is high only while a result is held and out_stall is high.
// Synchronous active-low reset returns to method start with cleared accumulators.
`timescale 1ns / 1ps
`default_nettype none

module http_request_header_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [2:0]       out_byte_role,
  output logic [7:0]       out_byte_out,
  output logic [15:0]      out_ver_major,
  output logic [15:0]      out_ver_minor
);

  hrhp_pkg::phase_t phase_r, phase_nxt;
  logic             header_seen_r, header_seen_nxt;
  logic [15:0]      major_acc_r, major_acc_nxt;
  logic [15:0]      minor_acc_r, minor_acc_nxt;
  logic [1:0]       status_nxt;
  logic [2:0]       role_nxt;
  logic             accept;

  logic             out_valid_r;
  logic [1:0]       status_r;
  logic [2:0]       role_r;
  logic [7:0]       byte_r;
  logic [15:0]      ver_major_r;
  logic [15:0]      ver_minor_r;

  // Handshake: output register frees up when empty or being taken
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= hrhp_pkg::PH_METHOD_START;
      header_seen_r <= 1'b0;
      major_acc_r   <= 16'd0;
      minor_acc_r   <= 16'd0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      header_seen_r <= header_seen_nxt;
      major_acc_r   <= major_acc_nxt;
      minor_acc_r   <= minor_acc_nxt;
    end
  end

  // Next phase, status and role for the byte at the input
  always_comb begin
    phase_nxt       = phase_r;
    header_seen_nxt = header_seen_r;
    major_acc_nxt   = major_acc_r;
    minor_acc_nxt   = minor_acc_r;
    status_nxt      = hrhp_pkg::ST_MORE;
    role_nxt        = hrhp_pkg::RL_NONE;
    unique case (phase_r)
      hrhp_pkg::PH_METHOD_START: begin
        if (hrhp_pkg::token_byte(in_byte)) begin
          phase_nxt = hrhp_pkg::PH_METHOD;
          role_nxt  = hrhp_pkg::RL_METHOD;
        end else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_METHOD: begin
        if (in_byte == hrhp_pkg::CH_SP) phase_nxt = hrhp_pkg::PH_URI;
        else if (hrhp_pkg::token_byte(in_byte)) role_nxt = hrhp_pkg::RL_METHOD;
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_URI: begin
        if (in_byte == hrhp_pkg::CH_SP) phase_nxt = hrhp_pkg::PH_V_H;
        else if (hrhp_pkg::ctl_byte(in_byte)) status_nxt = hrhp_pkg::ST_BAD;
        else role_nxt = hrhp_pkg::RL_URI;
      end
      hrhp_pkg::PH_V_H: begin
        if (in_byte == hrhp_pkg::CH_H) phase_nxt = hrhp_pkg::PH_V_T1;
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_T1: begin
        if (in_byte == hrhp_pkg::CH_T) phase_nxt = hrhp_pkg::PH_V_T2;
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_T2: begin
        if (in_byte == hrhp_pkg::CH_T) phase_nxt = hrhp_pkg::PH_V_P;
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_P: begin
        if (in_byte == hrhp_pkg::CH_P) phase_nxt = hrhp_pkg::PH_V_SLASH;
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_SLASH: begin
        // slash opens the version: clear both accumulators
        if (in_byte == hrhp_pkg::CH_SLASH) begin
          major_acc_nxt = 16'd0;
          minor_acc_nxt = 16'd0;
          phase_nxt     = hrhp_pkg::PH_MAJ_START;
        end else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MAJ_START: begin
        if (hrhp_pkg::digit_byte(in_byte)) begin
          major_acc_nxt = hrhp_pkg::acc_digit(major_acc_r, in_byte);
          phase_nxt     = hrhp_pkg::PH_MAJ;
        end else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MAJ: begin
        if (in_byte == hrhp_pkg::CH_DOT) phase_nxt = hrhp_pkg::PH_MIN_START;
        else if (hrhp_pkg::digit_byte(in_byte))
          major_acc_nxt = hrhp_pkg::acc_digit(major_acc_r, in_byte);
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MIN_START: begin
        if (hrhp_pkg::digit_byte(in_byte)) begin
          minor_acc_nxt = hrhp_pkg::acc_digit(minor_acc_r, in_byte);
          phase_nxt     = hrhp_pkg::PH_MIN;
        end else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MIN: begin
        if (in_byte == hrhp_pkg::CH_CR) phase_nxt = hrhp_pkg::PH_NL1;
        else if (hrhp_pkg::digit_byte(in_byte))
          minor_acc_nxt = hrhp_pkg::acc_digit(minor_acc_r, in_byte);
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_NL1: begin
        if (in_byte == hrhp_pkg::CH_LF) phase_nxt = hrhp_pkg::PH_LINE_START;
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_LINE_START: begin
        // continuation whitespace counts only after a header line has begun
        if (in_byte == hrhp_pkg::CH_CR) phase_nxt = hrhp_pkg::PH_NL3;
        else if (header_seen_r &&
                 (in_byte == hrhp_pkg::CH_SP || in_byte == hrhp_pkg::CH_TAB))
          phase_nxt = hrhp_pkg::PH_LWS;
        else if (hrhp_pkg::token_byte(in_byte)) begin
          header_seen_nxt = 1'b1;
          phase_nxt       = hrhp_pkg::PH_NAME;
          role_nxt        = hrhp_pkg::RL_NEW_NAME;
        end else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_LWS: begin
        if (in_byte == hrhp_pkg::CH_CR) phase_nxt = hrhp_pkg::PH_NL2;
        else if (in_byte == hrhp_pkg::CH_SP || in_byte == hrhp_pkg::CH_TAB) begin
          phase_nxt = hrhp_pkg::PH_LWS;
        end else if (hrhp_pkg::ctl_byte(in_byte)) status_nxt = hrhp_pkg::ST_BAD;
        else begin
          phase_nxt = hrhp_pkg::PH_VALUE;
          role_nxt  = hrhp_pkg::RL_VALUE;
        end
      end
      hrhp_pkg::PH_NAME: begin
        if (in_byte == hrhp_pkg::CH_COLON) phase_nxt = hrhp_pkg::PH_SP_VALUE;
        else if (hrhp_pkg::token_byte(in_byte)) role_nxt = hrhp_pkg::RL_NAME;
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_SP_VALUE: begin
        if (in_byte == hrhp_pkg::CH_SP) phase_nxt = hrhp_pkg::PH_VALUE;
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_VALUE: begin
        if (in_byte == hrhp_pkg::CH_CR) phase_nxt = hrhp_pkg::PH_NL2;
        else if (hrhp_pkg::ctl_byte(in_byte)) status_nxt = hrhp_pkg::ST_BAD;
        else role_nxt = hrhp_pkg::RL_VALUE;
      end
      hrhp_pkg::PH_NL2: begin
        if (in_byte == hrhp_pkg::CH_LF) phase_nxt = hrhp_pkg::PH_LINE_START;
        else status_nxt = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_NL3: begin
        // final LF: phase stays here, every later LF reports good again
        status_nxt = (in_byte == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_GOOD : hrhp_pkg::ST_BAD;
      end
      default: status_nxt = hrhp_pkg::ST_BAD;
    endcase
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (accept) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      role_r      <= role_nxt;
      byte_r      <= in_byte;
      ver_major_r <= major_acc_nxt;
      ver_minor_r <= minor_acc_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_byte_role = role_r;
  assign out_byte_out  = byte_r;
  assign out_ver_major = ver_major_r;
  assign out_ver_minor = ver_minor_r;

  // A bad byte never carries a role
  a_bad_no_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == hrhp_pkg::ST_BAD) |-> (role_r == hrhp_pkg::RL_NONE))
    else $error("bad result with a byte role");

  // A bad byte leaves the parse phase untouched
  a_bad_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status_nxt == hrhp_pkg::ST_BAD) |=> (phase_r == $past(phase_r)))
    else $error("phase moved on a bad byte");

  // Good status only from the final LF phase, which it keeps
  a_good_from_nl3: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status_nxt == hrhp_pkg::ST_GOOD) |=> (phase_r == hrhp_pkg::PH_NL3))
    else $error("good status outside the final LF phase");

  // Accumulators move only on an accepted word
  a_acc_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(major_acc_r) && $stable(minor_acc_r)))
    else $error("version accumulator changed without a word");

  // Reported versions track the accumulators
  a_ver_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (ver_major_r == major_acc_r) && (ver_minor_r == minor_acc_r))
    else $error("reported version differs from accumulator");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the HTTP request header parser: directed and random byte streams.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;

  // One result word of the parser
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  role;
    logic [7:0]  data;
    logic [15:0] major;
    logic [15:0] minor;
  } parse_word_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [2:0]  out_byte_role;
  logic [7:0]  out_byte_out;
  logic [15:0] out_ver_major;
  logic [15:0] out_ver_minor;

  // Parser state as predicted
  hrhp_pkg::phase_t cur_phase = hrhp_pkg::PH_METHOD_START;
  logic        hdr_seen  = 1'b0;
  logic [15:0] maj_acc   = 16'd0;
  logic [15:0] min_acc   = 16'd0;

  parse_word_t pending_words[$];
  int          err_count   = 0;
  int          word_count  = 0;
  int          item_count  = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;

  http_request_header_parser_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_byte_role (out_byte_role),
    .out_byte_out  (out_byte_out),
    .out_ver_major (out_ver_major),
    .out_ver_minor (out_ver_minor)
  );

  always #1 clk = ~clk;

  // Run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Character classes
  function automatic logic is_control(input logic [7:0] b);
    return (b < 8'd32) || (b == 8'd127);
  endfunction

  function automatic logic is_separator(input logic [7:0] b);
    case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", " ", 8'h09: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    return (b < 8'd128) && !is_control(b) && !is_separator(b);
  endfunction

  function automatic logic is_dec_char(input logic [7:0] b);
    return (b >= 8'd48) && (b <= 8'd57);
  endfunction

  // Decimal shift-in, clamped at 16 bits
  function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [7:0] b);
    int unsigned v;
    v = int'(acc) * 10 + int'(b) - 48;
    return (v > 65535) ? hrhp_pkg::VER_MAX : v[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Parse one byte: next state and the result word it yields
  task automatic parse_step(input logic [7:0] b, output parse_word_t w);
    logic [1:0]       st;
    logic [2:0]       role;
    hrhp_pkg::phase_t nxt;
    st   = hrhp_pkg::ST_MORE;
    role = hrhp_pkg::RL_NONE;
    nxt  = cur_phase;
    case (cur_phase)
      hrhp_pkg::PH_METHOD_START: begin
        if (is_token(b)) begin
          nxt  = hrhp_pkg::PH_METHOD;
          role = hrhp_pkg::RL_METHOD;
        end else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_METHOD: begin
        if (b == hrhp_pkg::CH_SP) nxt = hrhp_pkg::PH_URI;
        else if (is_token(b)) role = hrhp_pkg::RL_METHOD;
        else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_URI: begin
        if (b == hrhp_pkg::CH_SP) nxt = hrhp_pkg::PH_V_H;
        else if (is_control(b)) st = hrhp_pkg::ST_BAD;
        else role = hrhp_pkg::RL_URI;
      end
      hrhp_pkg::PH_V_H: begin
        if (b == hrhp_pkg::CH_H) nxt = hrhp_pkg::PH_V_T1; else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_T1: begin
        if (b == hrhp_pkg::CH_T) nxt = hrhp_pkg::PH_V_T2; else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_T2: begin
        if (b == hrhp_pkg::CH_T) nxt = hrhp_pkg::PH_V_P; else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_P: begin
        if (b == hrhp_pkg::CH_P) nxt = hrhp_pkg::PH_V_SLASH; else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_V_SLASH: begin
        if (b == hrhp_pkg::CH_SLASH) begin
          maj_acc = 16'd0;
          min_acc = 16'd0;
          nxt     = hrhp_pkg::PH_MAJ_START;
        end else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MAJ_START: begin
        if (is_dec_char(b)) begin
          maj_acc = add_digit(maj_acc, b);
          nxt     = hrhp_pkg::PH_MAJ;
        end else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MAJ: begin
        if (b == hrhp_pkg::CH_DOT) nxt = hrhp_pkg::PH_MIN_START;
        else if (is_dec_char(b)) maj_acc = add_digit(maj_acc, b);
        else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MIN_START: begin
        if (is_dec_char(b)) begin
          min_acc = add_digit(min_acc, b);
          nxt     = hrhp_pkg::PH_MIN;
        end else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_MIN: begin
        if (b == hrhp_pkg::CH_CR) nxt = hrhp_pkg::PH_NL1;
        else if (is_dec_char(b)) min_acc = add_digit(min_acc, b);
        else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_NL1: begin
        if (b == hrhp_pkg::CH_LF) nxt = hrhp_pkg::PH_LINE_START;
        else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_LINE_START: begin
        if (b == hrhp_pkg::CH_CR) nxt = hrhp_pkg::PH_NL3;
        else if (hdr_seen && (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_TAB))
          nxt = hrhp_pkg::PH_LWS;
        else if (is_token(b)) begin
          hdr_seen = 1'b1;
          nxt      = hrhp_pkg::PH_NAME;
          role     = hrhp_pkg::RL_NEW_NAME;
        end else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_LWS: begin
        if (b == hrhp_pkg::CH_CR) nxt = hrhp_pkg::PH_NL2;
        else if (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_TAB) nxt = hrhp_pkg::PH_LWS;
        else if (is_control(b)) st = hrhp_pkg::ST_BAD;
        else begin
          nxt  = hrhp_pkg::PH_VALUE;
          role = hrhp_pkg::RL_VALUE;
        end
      end
      hrhp_pkg::PH_NAME: begin
        if (b == hrhp_pkg::CH_COLON) nxt = hrhp_pkg::PH_SP_VALUE;
        else if (is_token(b)) role = hrhp_pkg::RL_NAME;
        else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_SP_VALUE: begin
        if (b == hrhp_pkg::CH_SP) nxt = hrhp_pkg::PH_VALUE; else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_VALUE: begin
        if (b == hrhp_pkg::CH_CR) nxt = hrhp_pkg::PH_NL2;
        else if (is_control(b)) st = hrhp_pkg::ST_BAD;
        else role = hrhp_pkg::RL_VALUE;
      end
      hrhp_pkg::PH_NL2: begin
        if (b == hrhp_pkg::CH_LF) nxt = hrhp_pkg::PH_LINE_START;
        else st = hrhp_pkg::ST_BAD;
      end
      hrhp_pkg::PH_NL3: begin
        st = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::ST_GOOD : hrhp_pkg::ST_BAD;
      end
      default: st = hrhp_pkg::ST_BAD;
    endcase
    cur_phase = nxt;
    w = '{status: st, role: role, data: b, major: maj_acc, minor: min_acc};
  endtask

  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] word %0d: %s", $realtime, word_count, msg);
    err_count++;
  endtask

  // Result checker: each accepted word against the oldest prediction
  always @(posedge clk) begin
    parse_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word, byte 0x%02h", out_byte_out));
      end else begin
        want = pending_words.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d (byte 0x%02h)",
                                    out_status, want.status, want.data));
        if (out_byte_role !== want.role)
          report_mismatch($sformatf("role %0d, expected %0d (byte 0x%02h)",
                                    out_byte_role, want.role, want.data));
        if (out_byte_out !== want.data)
          report_mismatch($sformatf("byte 0x%02h, expected 0x%02h", out_byte_out, want.data));
        if (out_ver_major !== want.major)
          report_mismatch($sformatf("major %0d, expected %0d", out_ver_major, want.major));
        if (out_ver_minor !== want.minor)
          report_mismatch($sformatf("minor %0d, expected %0d", out_ver_minor, want.minor));
      end
      word_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Send one byte; entered and left at a falling edge, valid left high
  task automatic send_byte(input logic [7:0] b);
    parse_word_t w;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    parse_step(b, w);
    pending_words.insert(pending_words.size(), w);
    item_count++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // A CR at line start would end the request for good; keep it out of noise
  task automatic send_guarded(input logic [7:0] b);
    if (cur_phase == hrhp_pkg::PH_LINE_START && b == hrhp_pkg::CH_CR)
      send_byte(hrhp_pkg::CH_LF);
    else send_byte(b);
  endtask

  // Hold the sender off until every word has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_token();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 126)); while (!is_token(b));
    return b;
  endfunction

  // Header value byte: printable ASCII or a high byte
  function automatic logic [7:0] rand_value();
    if ($urandom_range(9) < 3) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  // Push the parser back to a line start after a damaged line
  task automatic resync_line();
    while (cur_phase != hrhp_pkg::PH_LINE_START && cur_phase != hrhp_pkg::PH_NL3) begin
      case (cur_phase)
        hrhp_pkg::PH_NAME:     send_byte(hrhp_pkg::CH_COLON);
        hrhp_pkg::PH_SP_VALUE: send_byte(hrhp_pkg::CH_SP);
        hrhp_pkg::PH_NL2:      send_byte(hrhp_pkg::CH_LF);
        default:               send_byte(hrhp_pkg::CH_CR);
      endcase
    end
  endtask

  // One header or continuation line, sometimes damaged, with noise bytes
  task automatic send_header_line();
    logic [7:0] line[$];
    int         pos;
    if (hdr_seen && $urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3))
        line.insert(line.size(), $urandom_range(1) ? hrhp_pkg::CH_SP : hrhp_pkg::CH_TAB);
    end else begin
      line.insert(line.size(), rand_token());
      repeat ($urandom_range(0, 6)) line.insert(line.size(), rand_token());
      line.insert(line.size(), hrhp_pkg::CH_COLON);
      line.insert(line.size(), hrhp_pkg::CH_SP);
    end
    repeat ($urandom_range(0, 10)) line.insert(line.size(), rand_value());
    line.insert(line.size(), hrhp_pkg::CH_CR);
    line.insert(line.size(), hrhp_pkg::CH_LF);
    // damaged line: one byte dropped or overwritten
    if ($urandom_range(7) == 0) begin
      pos = $urandom_range(line.size() - 1);
      if ($urandom_range(1)) line.delete(pos);
      else line[pos] = 8'($urandom_range(255));
    end
    foreach (line[i]) begin
      if ($urandom_range(9) == 0) send_guarded(8'($urandom_range(255)));
      send_guarded(line[i]);
    end
    resync_line();
  endtask

  // ---------------------------------------------------------------------------
  // Method and URI, with bad bytes at each step
  task automatic test_request_line();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(hrhp_pkg::CH_SP);
    send_text("GE");
    send_byte(8'h80);
    send_text("T ");
    send_byte(8'hFF);
    send_byte(hrhp_pkg::CH_DEL);
    send_text("/a ");
  endtask

  // Version literal, slash clear and saturating digits
  task automatic test_version();
    send_text("xHTTP1/.");
    send_text("700000.");
    send_text("65535");
    send_text("9a");
    send_byte(hrhp_pkg::CH_CR);
    send_text("A");
    send_byte(hrhp_pkg::CH_LF);
  endtask

  // Whitespace before any header, a header, then continuation lines
  task automatic test_headers();
    send_byte(hrhp_pkg::CH_SP);
    send_byte(hrhp_pkg::CH_TAB);
    send_text("Host: x");
    send_byte(hrhp_pkg::CH_CR);
    send_byte(hrhp_pkg::CH_LF);
    send_byte(hrhp_pkg::CH_SP);
    send_byte(hrhp_pkg::CH_TAB);
    send_byte(8'h01);
    send_byte(8'hC8);
    send_byte(hrhp_pkg::CH_CR);
    send_byte(hrhp_pkg::CH_LF);
    send_byte(hrhp_pkg::CH_SP);
    send_byte(hrhp_pkg::CH_CR);
    send_byte(hrhp_pkg::CH_LF);
  endtask

  task automatic test_random_headers(input int idle, input int stall, input int n);
    int stop_at;
    send_idle_pct = idle;
    stall_pct     = stall;
    stop_at       = item_count + n;
    while (item_count < stop_at) send_header_line();
    wait_results_done();
  endtask

  // Blank line ends the request; afterwards only LF is good
  task automatic test_completion();
    send_idle_pct = 10;
    stall_pct     = 10;
    send_byte(hrhp_pkg::CH_CR);
    send_byte(hrhp_pkg::CH_LF);
    send_byte("A");
    send_byte(hrhp_pkg::CH_LF);
    send_byte(hrhp_pkg::CH_CR);
    send_byte(hrhp_pkg::CH_LF);
    wait_results_done();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_request_line();
    test_version();
    test_headers();
    wait_results_done();
    test_random_headers(0, 0, 150);
    test_random_headers(52, 0, 150);
    test_random_headers(0, 52, 150);
    test_random_headers(10, 10, 150);
    test_completion();
    if (err_count == 0 && pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- http_request_header_parser_top.f -----
hw/rtl/hrhp_pkg.sv
hw/rtl/http_request_header_parser_top.sv
dv/testbench.sv
